@@ rtl/kst_pkg.sv @@
`timescale 1ns / 1ps
// Package for the k-smallest max-heap tracker: widths, the heap entry type,
// datapath operation codes, controller states and the status bundle.
// No dependencies.
package kst_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 32;
  localparam int POS_W        = 24;
  localparam int SIZE_W       = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        position;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START_UP,
    OP_START_DN,
    OP_REJECT,
    OP_RD_PARENT,
    OP_UP_MOVE,
    OP_PLACE,
    OP_RD_LEFT,
    OP_RD_RIGHT,
    OP_DN_MOVE,
    OP_DUMP_START,
    OP_DUMP_RD,
    OP_DUMP_EMIT,
    OP_EMIT_OFFER,
    OP_EMIT_EMPTY
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_UP_CHECK,
    ST_UP_CMP,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_DN_CMP,
    ST_DUMP_RD,
    ST_DUMP_EMIT,
    ST_EMIT_OFFER,
    ST_EMIT_EMPTY
  } ctrl_state_t;

  typedef struct packed {
    logic is_dump;
    logic has_room;
    logic lt_root;
    logic fill_zero;
    logic at_root;
    logic parent_lt;
    logic l_in;
    logic dn_stop;
    logic dump_last;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/kst_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tracker: offer/dump items in,
// result items out. Depends on kst_pkg for field widths.
interface kst_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [kst_pkg::KEY_W-1:0] key;
  logic [kst_pkg::POS_W-1:0]   position;

  modport source (output valid, output kind, output key, output position, input ready);
  modport sink (input valid, input kind, input key, input position, output ready);
endinterface

interface kst_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic                        valid_res;
  logic signed [kst_pkg::KEY_W-1:0] out_key;
  logic [kst_pkg::POS_W-1:0]   out_position;
  logic                        last;

  modport source (output valid, output accepted, output valid_res, output out_key,
                  output out_position, output last, input ready);
  modport sink (input valid, input accepted, input valid_res, input out_key,
                input out_position, input last, output ready);
endinterface

@@ rtl/kst_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the tracker: heap memory, root mirror, sift registers, fill
// count, size register and the result register. Depends on kst_pkg.
module kst_dp #(
  parameter int CAPACITY = kst_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kst_pkg::dp_op_t               op,
  output kst_pkg::stat_t                stat,
  input  logic                          in_kind,
  input  logic signed [kst_pkg::KEY_W-1:0] in_key,
  input  logic [kst_pkg::POS_W-1:0]     in_position,
  input  logic                          size_we,
  input  logic [kst_pkg::SIZE_W-1:0]    size_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_accepted,
  output logic                          out_valid_res,
  output logic signed [kst_pkg::KEY_W-1:0] out_key,
  output logic [kst_pkg::POS_W-1:0]     out_position,
  output logic                          out_last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > kst_pkg::SIZE_W) ? FW : kst_pkg::SIZE_W;
  localparam int XW = (IW + 2 > FW) ? IW + 2 : FW;

  kst_pkg::entry_t mem [CAPACITY];
  kst_pkg::entry_t rd_data;
  kst_pkg::entry_t root;
  kst_pkg::entry_t carry;
  kst_pkg::entry_t left;
  logic            kind;
  logic            acc;
  logic [IW-1:0]   idx;
  logic [FW-1:0]   fill;
  logic [kst_pkg::SIZE_W-1:0] heap_size;

  logic            mem_we;
  logic [IW-1:0]   waddr;
  kst_pkg::entry_t wdata;
  logic            mem_re;
  logic [IW-1:0]   raddr;
  logic            out_load;

  logic [CW-1:0]   size_ext;
  logic [CW-1:0]   limit;
  logic [IW-1:0]   parent;
  logic [IW:0]     lchild;
  logic [XW-1:0]   rchild;
  logic            r_in;
  logic            sel_left;
  logic            sel_right;
  logic signed [kst_pkg::KEY_W-1:0] top_key;

  // Limit in force is the size register clamped to 1..CAPACITY.
  always_comb begin
    size_ext = CW'(heap_size);
    if (size_ext == '0) begin
      limit = CW'(1);
    end else if (size_ext > CW'(CAPACITY)) begin
      limit = CW'(CAPACITY);
    end else begin
      limit = size_ext;
    end
  end

  assign parent = IW'((idx - IW'(1)) >> 1);
  assign lchild = {idx, 1'b1};
  assign rchild = XW'(lchild) + XW'(1);
  assign r_in   = rchild < XW'(fill);

  // In the compare state the read register holds the right child.
  assign sel_left  = $signed(left.key) > $signed(carry.key);
  assign top_key   = sel_left ? left.key : carry.key;
  assign sel_right = r_in && ($signed(rd_data.key) > $signed(top_key));

  always_comb begin
    stat.is_dump   = kind;
    stat.has_room  = CW'(fill) < limit;
    stat.lt_root   = $signed(carry.key) < $signed(root.key);
    stat.fill_zero = fill == '0;
    stat.at_root   = idx == '0;
    stat.parent_lt = $signed(rd_data.key) < $signed(carry.key);
    stat.l_in      = XW'(lchild) < XW'(fill);
    stat.dn_stop   = !sel_left && !sel_right;
    stat.dump_last = (FW'(idx) + FW'(1)) == fill;
    stat.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = idx;
    wdata  = carry;
    mem_re = 1'b0;
    raddr  = idx;
    case (op)
      kst_pkg::OP_PLACE: begin
        mem_we = 1'b1;
      end
      kst_pkg::OP_UP_MOVE: begin
        mem_we = 1'b1;
        wdata  = rd_data;
      end
      kst_pkg::OP_DN_MOVE: begin
        mem_we = 1'b1;
        wdata  = sel_right ? rd_data : left;
      end
      kst_pkg::OP_RD_PARENT: begin
        mem_re = 1'b1;
        raddr  = parent;
      end
      kst_pkg::OP_RD_LEFT: begin
        mem_re = 1'b1;
        raddr  = lchild[IW-1:0];
      end
      kst_pkg::OP_RD_RIGHT: begin
        mem_re = r_in;
        raddr  = rchild[IW-1:0];
      end
      kst_pkg::OP_DUMP_RD: begin
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_load = (op == kst_pkg::OP_EMIT_OFFER) || (op == kst_pkg::OP_EMIT_EMPTY) ||
                    (op == kst_pkg::OP_DUMP_EMIT);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && (waddr == '0)) begin
      root <= wdata;
    end
    case (op)
      kst_pkg::OP_LOAD: begin
        kind           <= in_kind;
        carry.key      <= in_key;
        carry.position <= in_position;
      end
      kst_pkg::OP_START_UP: begin
        idx <= fill[IW-1:0];
        acc <= 1'b1;
      end
      kst_pkg::OP_START_DN: begin
        idx <= '0;
        acc <= 1'b1;
      end
      kst_pkg::OP_REJECT: begin
        acc <= 1'b0;
      end
      kst_pkg::OP_UP_MOVE: begin
        idx <= parent;
      end
      kst_pkg::OP_RD_RIGHT: begin
        left <= rd_data;
      end
      kst_pkg::OP_DN_MOVE: begin
        idx <= sel_right ? rchild[IW-1:0] : lchild[IW-1:0];
      end
      kst_pkg::OP_DUMP_START: begin
        idx <= '0;
      end
      kst_pkg::OP_DUMP_EMIT: begin
        idx <= IW'(idx + IW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      heap_size <= kst_pkg::SIZE_RESET;
    end else begin
      if (op == kst_pkg::OP_START_UP) begin
        fill <= FW'(fill + FW'(1));
      end
      if (size_we) begin
        heap_size <= size_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      kst_pkg::OP_EMIT_OFFER: begin
        out_accepted  <= acc;
        out_valid_res <= 1'b1;
        out_key       <= root.key;
        out_position  <= root.position;
        out_last      <= 1'b1;
      end
      kst_pkg::OP_DUMP_EMIT: begin
        out_accepted  <= 1'b0;
        out_valid_res <= 1'b1;
        out_key       <= rd_data.key;
        out_position  <= rd_data.position;
        out_last      <= stat.dump_last;
      end
      kst_pkg::OP_EMIT_EMPTY: begin
        out_accepted  <= 1'b0;
        out_valid_res <= 1'b0;
        out_key       <= '0;
        out_position  <= '0;
        out_last      <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The root mirror must follow every write to the top of the heap.
  a_root_mirror: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (waddr == '0)) |=> (root == $past(wdata)))
    else $error("root register out of step with heap entry zero");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (op == kst_pkg::OP_START_UP) |-> stat.has_room)
    else $error("append started on a full heap");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (op == kst_pkg::OP_START_UP) |=> (fill == FW'($past(fill) + FW'(1))))
    else $error("fill count did not advance on append");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

endmodule

@@ rtl/kst_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the tracker: sequences load, sift-up,
// sift-down, dump and result steps of the datapath. Depends on kst_pkg.
module kst_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  kst_pkg::stat_t  stat,
  output kst_pkg::dp_op_t op
);

  kst_pkg::ctrl_state_t state;
  kst_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kst_pkg::ST_IDLE: begin
        if (in_valid) state_next = kst_pkg::ST_DECIDE;
      end
      kst_pkg::ST_DECIDE: begin
        if (stat.is_dump) begin
          state_next = stat.fill_zero ? kst_pkg::ST_EMIT_EMPTY : kst_pkg::ST_DUMP_RD;
        end else if (stat.has_room) begin
          state_next = kst_pkg::ST_UP_CHECK;
        end else if (stat.lt_root) begin
          state_next = kst_pkg::ST_DN_LEFT;
        end else begin
          state_next = kst_pkg::ST_EMIT_OFFER;
        end
      end
      kst_pkg::ST_UP_CHECK: begin
        state_next = stat.at_root ? kst_pkg::ST_EMIT_OFFER : kst_pkg::ST_UP_CMP;
      end
      kst_pkg::ST_UP_CMP: begin
        state_next = stat.parent_lt ? kst_pkg::ST_UP_CHECK : kst_pkg::ST_EMIT_OFFER;
      end
      kst_pkg::ST_DN_LEFT: begin
        state_next = stat.l_in ? kst_pkg::ST_DN_RIGHT : kst_pkg::ST_EMIT_OFFER;
      end
      kst_pkg::ST_DN_RIGHT: begin
        state_next = kst_pkg::ST_DN_CMP;
      end
      kst_pkg::ST_DN_CMP: begin
        state_next = stat.dn_stop ? kst_pkg::ST_EMIT_OFFER : kst_pkg::ST_DN_LEFT;
      end
      kst_pkg::ST_DUMP_RD: begin
        state_next = kst_pkg::ST_DUMP_EMIT;
      end
      kst_pkg::ST_DUMP_EMIT: begin
        if (stat.out_free) begin
          state_next = stat.dump_last ? kst_pkg::ST_IDLE : kst_pkg::ST_DUMP_RD;
        end
      end
      kst_pkg::ST_EMIT_OFFER, kst_pkg::ST_EMIT_EMPTY: begin
        if (stat.out_free) state_next = kst_pkg::ST_IDLE;
      end
      default: begin
        state_next = kst_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    op       = kst_pkg::OP_NONE;
    in_ready = 1'b0;
    case (state)
      kst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = kst_pkg::OP_LOAD;
      end
      kst_pkg::ST_DECIDE: begin
        if (stat.is_dump) begin
          op = stat.fill_zero ? kst_pkg::OP_NONE : kst_pkg::OP_DUMP_START;
        end else if (stat.has_room) begin
          op = kst_pkg::OP_START_UP;
        end else if (stat.lt_root) begin
          op = kst_pkg::OP_START_DN;
        end else begin
          op = kst_pkg::OP_REJECT;
        end
      end
      kst_pkg::ST_UP_CHECK: begin
        op = stat.at_root ? kst_pkg::OP_PLACE : kst_pkg::OP_RD_PARENT;
      end
      kst_pkg::ST_UP_CMP: begin
        op = stat.parent_lt ? kst_pkg::OP_UP_MOVE : kst_pkg::OP_PLACE;
      end
      kst_pkg::ST_DN_LEFT: begin
        op = stat.l_in ? kst_pkg::OP_RD_LEFT : kst_pkg::OP_PLACE;
      end
      kst_pkg::ST_DN_RIGHT: begin
        op = kst_pkg::OP_RD_RIGHT;
      end
      kst_pkg::ST_DN_CMP: begin
        op = stat.dn_stop ? kst_pkg::OP_PLACE : kst_pkg::OP_DN_MOVE;
      end
      kst_pkg::ST_DUMP_RD: begin
        op = kst_pkg::OP_DUMP_RD;
      end
      kst_pkg::ST_DUMP_EMIT: begin
        if (stat.out_free) op = kst_pkg::OP_DUMP_EMIT;
      end
      kst_pkg::ST_EMIT_OFFER: begin
        if (stat.out_free) op = kst_pkg::OP_EMIT_OFFER;
      end
      kst_pkg::ST_EMIT_EMPTY: begin
        if (stat.out_free) op = kst_pkg::OP_EMIT_EMPTY;
      end
      default: begin
      end
    endcase
  end

  // Every sift ends by placing the carried entry before its result is sent.
  a_up_end: assert property (@(posedge clk) disable iff (rst)
    ((state == kst_pkg::ST_UP_CMP) && !stat.parent_lt) |-> (op == kst_pkg::OP_PLACE))
    else $error("sift-up ended without placing the entry");

  a_dn_end: assert property (@(posedge clk) disable iff (rst)
    ((state == kst_pkg::ST_DN_CMP) && stat.dn_stop) |=>
      (state == kst_pkg::ST_EMIT_OFFER))
    else $error("sift-down stop did not lead to the result");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (op == kst_pkg::OP_LOAD) |=> !in_ready)
    else $error("new transaction taken while one is in work");

endmodule

@@ rtl/k_smallest_max_heap_tracker_top.sv @@
`timescale 1ns / 1ps
// Top level of the k-smallest max-heap tracker: controller plus datapath.
// Depends on kst_pkg, kst_in_if/kst_out_if, kst_ctrl and kst_dp.
//
//   Port             Dir   Carries
//   item             in    kind, key, position (valid/ready)
//   result           out   accepted, valid_res, out_key, out_position, last
//   heap_size_we/    in    write of the heap_size register
//   heap_size_wdata
//
// An item is taken only when the controller is idle; one transaction is worked
// at a time, through a single-port heap memory with a registered read.
// Offer: a rejected offer goes straight to its result. An append sifts up from
// the fill position, moving each smaller parent down, then places the entry. A
// replace sifts down from the root, moving the larger child up while it exceeds
// the entry, then places it. Dump: each held entry is read and emitted in turn.
// Results wait in an output register, so the next transaction is taken while a
// result is still held; a result that finds the register held stalls its item.
// Synchronous reset empties the heap and sets heap_size to 16; no clearing pass.
module k_smallest_max_heap_tracker_top #(
  parameter int CAPACITY = kst_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  kst_in_if.sink                     item,
  kst_out_if.source                  result,
  input  logic                       heap_size_we,
  input  logic [kst_pkg::SIZE_W-1:0] heap_size_wdata
);

  kst_pkg::dp_op_t op;
  kst_pkg::stat_t  stat;

  kst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .stat     (stat),
    .op       (op)
  );

  kst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .stat          (stat),
    .in_kind       (item.kind),
    .in_key        (item.key),
    .in_position   (item.position),
    .size_we       (heap_size_we),
    .size_wdata    (heap_size_wdata),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_accepted  (result.accepted),
    .out_valid_res (result.valid_res),
    .out_key       (result.out_key),
    .out_position  (result.out_position),
    .out_last      (result.last)
  );

endmodule
